@@ rtl/q15_biquad_filter_top_macros.svh @@
// assertion macros shared by the q15 biquad checker
// no dependencies; included by files that hold concurrent assertions
`ifndef Q15_BIQUAD_FILTER_TOP_MACROS_SVH
`define Q15_BIQUAD_FILTER_TOP_MACROS_SVH

// property checked on every edge outside reset
`define Q15BQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property that must also hold across reset
`define Q15BQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/q15bq_pkg.sv @@
// widths, constants and register map of the q15 biquad filter
// no dependencies; used by the top level and its checker
`timescale 1ns / 1ps

package q15bq_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = 64;
  localparam int FRAC_BITS = 15;
  localparam int SHIFT_W   = ACC_W - FRAC_BITS;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  // cycles from an input transaction to the earliest output transaction of its result
  localparam int LATENCY   = 6;

  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(64'h4000);

  typedef enum logic [2:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_t;

endpackage

@@ rtl/q15_biquad_filter_top.sv @@
// q15 biquad filter, transposed direct form ii, one shared multiplier
// depends on q15bq_pkg
`timescale 1ns / 1ps

// Second-order IIR filter on signed 32-bit samples. Each input transaction
// carries the sample in s_tdata, a restart flag in s_tuser (clears both 64-bit
// state words before the sample is filtered) and a frame marker in s_tlast,
// which comes back unchanged on m_tlast with the filtered sample in m_tdata.
// Output: y = sat32((x*b0 + s0 + 0x4000) >>> 15); then s0 = x*b1 + y*a1 + s1
// and s1 = x*b2 + y*a2. All five products go through one 32x16 multiplier,
// one product per cycle unless a finished sample waits in ST_FIN for a held
// output register: x*b0 as the sample is taken, then x*b1, y*a1, x*b2 and
// y*a2 in ST_Y, ST_A1, ST_B2 and ST_A2; ST_FIN writes the result to the
// output register. s_tready is low while a sample is being worked on and
// rises again in the cycle the result is written to the output register.
// A held output register does not block the next input until that next
// sample reaches its last step. The five Q15 coefficients sit at byte
// addresses 0,4,8,12,16 (b0,b1,b2,a1,a2) of the APB port; write them only
// while the block is idle. State is kept across frames and cleared by reset.
module q15_biquad_filter_top (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample_in
  input  logic        s_tuser,   // [0] restart
  input  logic        s_tlast,   // frame_end
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] sample_out
  output logic        m_tlast,   // frame_end_out
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [q15bq_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    ST_IDLE,  // waiting for a sample
    ST_Y,     // output from x*b0, multiply x*b1
    ST_A1,    // multiply y*a1, start s0
    ST_B2,    // finish s0, multiply x*b2
    ST_A2,    // multiply y*a2, start s1
    ST_FIN    // finish s1, write result
  } state_t;

  state_t state;

  // coefficient registers
  logic signed [q15bq_pkg::COEF_W-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;

  // filter state words
  logic signed [q15bq_pkg::ACC_W-1:0] s0, s1;

  // datapath registers
  logic signed [q15bq_pkg::SAMPLE_W-1:0] x_reg;
  logic signed [q15bq_pkg::SAMPLE_W-1:0] y_reg;
  logic                                   last_reg;
  logic signed [q15bq_pkg::PROD_W-1:0]   prod;
  logic signed [q15bq_pkg::ACC_W-1:0]    acc;

  // shared multiplier
  logic signed [q15bq_pkg::SAMPLE_W-1:0] mul_a;
  logic signed [q15bq_pkg::COEF_W-1:0]   mul_b;
  logic signed [q15bq_pkg::PROD_W-1:0]   mul_p;

  logic signed [q15bq_pkg::ACC_W-1:0]    prod_ext;
  logic signed [q15bq_pkg::ACC_W-1:0]    sum_y;
  logic signed [q15bq_pkg::SHIFT_W-1:0]  y_shift;
  logic signed [q15bq_pkg::SAMPLE_W-1:0] y_sat;

  logic in_acc;     // input transaction this cycle
  logic out_free;   // output register can take a result
  logic fin_go;     // last step completes this cycle
  logic cfg_wr;
  q15bq_pkg::reg_idx_t cfg_idx;

  assign out_free = !m_tvalid || m_tready;
  assign fin_go   = (state == ST_FIN) && out_free;
  assign s_tready = (state == ST_IDLE) || fin_go;
  assign in_acc   = s_tvalid && s_tready;

  // ---------------------------------------------------------------------
  // operand selection for the shared multiplier
  // ---------------------------------------------------------------------
  always_comb begin
    mul_a = x_reg;
    mul_b = coef_b0;
    if (in_acc) begin
      mul_a = s_tdata;
      mul_b = coef_b0;
    end else begin
      case (state)
        ST_Y: begin
          mul_a = x_reg;
          mul_b = coef_b1;
        end
        ST_A1: begin
          mul_a = y_reg;
          mul_b = coef_a1;
        end
        ST_B2: begin
          mul_a = x_reg;
          mul_b = coef_b2;
        end
        ST_A2: begin
          mul_a = y_reg;
          mul_b = coef_a2;
        end
        default: begin
          mul_a = x_reg;
          mul_b = coef_b0;
        end
      endcase
    end
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_ext = {{(q15bq_pkg::ACC_W - q15bq_pkg::PROD_W){prod[q15bq_pkg::PROD_W-1]}}, prod};

  // rounding, arithmetic shift and saturation of the output sample
  assign sum_y   = prod_ext + s0 + $signed(q15bq_pkg::ROUND_HALF);
  assign y_shift = sum_y[q15bq_pkg::ACC_W-1:q15bq_pkg::FRAC_BITS];

  always_comb begin
    if (!y_shift[q15bq_pkg::SHIFT_W-1] &&
        (|y_shift[q15bq_pkg::SHIFT_W-2:q15bq_pkg::SAMPLE_W-1])) begin
      y_sat = {1'b0, {(q15bq_pkg::SAMPLE_W-1){1'b1}}};
    end else if (y_shift[q15bq_pkg::SHIFT_W-1] &&
                 !(&y_shift[q15bq_pkg::SHIFT_W-2:q15bq_pkg::SAMPLE_W-1])) begin
      y_sat = {1'b1, {(q15bq_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      y_sat = y_shift[q15bq_pkg::SAMPLE_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // sequencer, state words and output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      s0       <= '0;
      s1       <= '0;
    end else begin
      if (fin_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state <= ST_Y;
            // a restart clears both state words before the new sample is used
            if (s_tuser) begin
              s0 <= '0;
              s1 <= '0;
            end
          end
        end
        ST_Y: begin
          y_reg <= y_sat;
          state <= ST_A1;
        end
        ST_A1: begin
          acc   <= prod_ext + s1;
          state <= ST_B2;
        end
        ST_B2: begin
          s0    <= acc + prod_ext;
          state <= ST_A2;
        end
        ST_A2: begin
          acc   <= prod_ext;
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_go) begin
            m_tdata  <= y_reg;
            m_tlast  <= last_reg;
            state    <= in_acc ? ST_Y : ST_IDLE;
            // a restart on the next sample overrides the state update
            if (in_acc && s_tuser) begin
              s0 <= '0;
              s1 <= '0;
            end else begin
              s1 <= acc + prod_ext;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    // hold the last product while the finished sample waits for the output
    if (state != ST_FIN || fin_go) begin
      prod <= mul_p;
    end
    if (in_acc) begin
      x_reg    <= s_tdata;
      last_reg <= s_tlast;
    end
  end

  // ---------------------------------------------------------------------
  // apb configuration port
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = q15bq_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= '0;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        q15bq_pkg::REG_B0: coef_b0 <= pwdata[q15bq_pkg::COEF_W-1:0];
        q15bq_pkg::REG_B1: coef_b1 <= pwdata[q15bq_pkg::COEF_W-1:0];
        q15bq_pkg::REG_B2: coef_b2 <= pwdata[q15bq_pkg::COEF_W-1:0];
        q15bq_pkg::REG_A1: coef_a1 <= pwdata[q15bq_pkg::COEF_W-1:0];
        q15bq_pkg::REG_A2: coef_a2 <= pwdata[q15bq_pkg::COEF_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      q15bq_pkg::REG_B0: prdata = {{(q15bq_pkg::DATA_W - q15bq_pkg::COEF_W){1'b0}}, coef_b0};
      q15bq_pkg::REG_B1: prdata = {{(q15bq_pkg::DATA_W - q15bq_pkg::COEF_W){1'b0}}, coef_b1};
      q15bq_pkg::REG_B2: prdata = {{(q15bq_pkg::DATA_W - q15bq_pkg::COEF_W){1'b0}}, coef_b2};
      q15bq_pkg::REG_A1: prdata = {{(q15bq_pkg::DATA_W - q15bq_pkg::COEF_W){1'b0}}, coef_a1};
      q15bq_pkg::REG_A2: prdata = {{(q15bq_pkg::DATA_W - q15bq_pkg::COEF_W){1'b0}}, coef_a2};
      default:           prdata = '0;
    endcase
  end

endmodule

@@ rtl/q15bq_checker.sv @@
// port-level checks of the q15 biquad filter, bound to the top level
// depends on q15bq_pkg and q15_biquad_filter_top_macros.svh
`timescale 1ns / 1ps
`include "q15_biquad_filter_top_macros.svh"

module q15bq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  // busy right after taking a sample
  `Q15BQ_ASSERT(a_busy_after_accept, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "ready high right after an input transaction")

  // a fresh result only follows an input transaction at the fixed latency
  `Q15BQ_ASSERT(a_result_latency, clk, rst, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, q15bq_pkg::LATENCY), "result without matching input transaction")

  // a stalled result holds
  `Q15BQ_ASSERT(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)), "stalled output changed")

  // reset empties the output and frees the input
  `Q15BQ_ASSERT_ALWAYS(a_reset_state, clk, rst |=> (!m_tvalid && s_tready), "output not empty after reset")

endmodule

bind q15_biquad_filter_top q15bq_checker u_q15bq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
